// ===== rtl/tbc_pkg.sv =====
// Shared types and constants for the toy block cipher pipeline.
package tbc_pkg;

    // Block geometry and alphabet
    localparam int          BLOCK_BYTES     = 16;
    localparam int          KEY_MAX_LETTERS = 16;
    localparam logic [7:0]  LETTER_A        = 8'h41;
    localparam logic [7:0]  LETTER_Z        = 8'h5A;
    localparam logic [7:0]  PAD_LETTER      = 8'h41;
    localparam logic [7:0]  GF_REDUCE       = 8'h1B;
    localparam logic [5:0]  ALPHABET        = 6'd26;

    // Configuration register indexes (byte address = 8 * index)
    localparam logic [1:0]  REG_KEY_LENGTH  = 2'd0;
    localparam logic [1:0]  REG_KEY_LOW     = 2'd1;
    localparam logic [1:0]  REG_KEY_HIGH    = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic calc_shift;
        logic store;
        logic finish;
        logic emit;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_finish;
        logic emit_done;
    } dp_status_t;

    // Configuration values seen by the datapath
    typedef struct packed {
        logic [4:0]  key_length;
        logic [63:0] key_low;
        logic [63:0] key_high;
    } key_cfg_t;

endpackage

// ===== rtl/toy_block_cipher_pipeline_top.sv =====
// Toy block cipher pipeline: an input byte is taken when start is high and busy is low.
// After capture, each byte keeps busy high through the key shift and store states, and
// no new byte is taken until the block is idle again. A byte that completes a block, or
// a message-end byte that leaves a partial block, adds row rotation, parity and
// MixColumns and then sixteen bytes of output, one byte per cycle with out_valid high;
// busy falls after the sixteenth byte. The single output byte port sets that rate.
// Results cannot be stalled; the receiver must take every byte in the cycle it is shown.
// Configuration (key length, key letters at byte addresses 0, 8 and 16) must be written
// over the APB-style port while busy is low; the block itself does not enforce this.
module toy_block_cipher_pipeline_top
    import tbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  in_char,
    input  logic        in_last,
    output logic        out_valid,
    output logic [7:0]  out_byte,
    output logic        out_last,
    output logic        out_msg_end,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    key_cfg_t   cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    tbc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tbc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    tbc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg         (cfg),
        .in_char     (in_char),
        .in_last     (in_last),
        .out_valid   (out_valid),
        .out_byte    (out_byte),
        .out_last    (out_last),
        .out_msg_end (out_msg_end)
    );

    // Results only while the block is busy
    a_out_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> busy)
        else $error("result transfer while idle");

    // Message-end flag only on the closing byte of a block
    a_msg_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_msg_end |-> (out_valid && out_last))
        else $error("message end outside the closing byte");

    // The closing byte of a block ends the burst
    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_last) |=> (!out_valid && !busy))
        else $error("output continues past the closing byte");

    // An accepted item makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !out_valid))
        else $error("accepted item did not start work");

endmodule

// ===== rtl/tbc_cfg.sv =====
// APB-style configuration registers: key length and key letters.
module tbc_cfg
    import tbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output key_cfg_t    cfg
);

    logic [4:0]  key_length_reg;
    logic [63:0] key_low_reg;
    logic [63:0] key_high_reg;
    logic        wr_en;
    logic [1:0]  reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[4:3];

    // Register writes on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= 5'd1;
            key_low_reg    <= 64'h4141414141414141;
            key_high_reg   <= 64'h4141414141414141;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_KEY_LENGTH: key_length_reg <= pwdata[4:0];
                REG_KEY_LOW:    key_low_reg    <= pwdata;
                REG_KEY_HIGH:   key_high_reg   <= pwdata;
                default:        ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_sel)
            REG_KEY_LENGTH: prdata = {59'd0, key_length_reg};
            REG_KEY_LOW:    prdata = key_low_reg;
            REG_KEY_HIGH:   prdata = key_high_reg;
            default:        prdata = 64'd0;
        endcase
    end

    assign cfg.key_length = key_length_reg;
    assign cfg.key_low    = key_low_reg;
    assign cfg.key_high   = key_high_reg;

endmodule

// ===== rtl/tbc_ctrl.sv =====
// Controller state machine: sequences capture, key shift, store, mix and output.
module tbc_ctrl
    import tbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_KEY   = 3'd1;
    localparam logic [2:0] ST_STORE = 3'd2;
    localparam logic [2:0] ST_FIN   = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_KEY;
                end
            end
            ST_KEY:
            begin
                cmd.calc_shift = 1'b1;
                state_next     = ST_STORE;
            end
            ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = status.need_finish ? ST_FIN : ST_IDLE;
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.emit_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== rtl/tbc_dp.sv =====
// Datapath: Vigenere shift, block store, row rotation, parity, MixColumns, output.
module tbc_dp
    import tbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    input  key_cfg_t   cfg,
    input  logic [7:0] in_char,
    input  logic       in_last,
    output logic       out_valid,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic       out_msg_end
);

    // GF(2^8) doubling
    function automatic logic [7:0] xtime(input logic [7:0] x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? GF_REDUCE : 8'h00);
    endfunction

    // Set bit 7 when bits 6..0 hold an odd number of ones
    function automatic logic [7:0] add_parity(input logic [7:0] c);
        add_parity = {c[7] | (^c[6:0]), c[6:0]};
    endfunction

    // (k + 195) mod 26 through a reciprocal multiply; v stays below 451
    function automatic logic [4:0] key_shift(input logic [7:0] k);
        logic [8:0]  v;
        logic [20:0] prod;
        logic [4:0]  q;
        logic [8:0]  qm;
        logic [8:0]  r;
        v    = {1'b0, k} + 9'd195;
        prod = 21'(v) * 21'd2521;
        q    = prod[20:16];
        qm   = 9'(q) * 9'd26;
        r    = v - qm;
        key_shift = r[4:0];
    endfunction

    logic [7:0]  char_reg;
    logic        last_reg;
    logic [4:0]  shift_reg;
    logic [3:0]  fill_reg;
    logic [3:0]  keypos_reg;
    logic        pad_en_reg;
    logic [3:0]  pad_fill_reg;
    logic        msg_end_reg;
    logic [3:0]  cnt_reg;
    logic [7:0]  store_reg [BLOCK_BYTES];
    logic [7:0]  res_reg   [BLOCK_BYTES];

    logic [4:0]  eff_len;
    logic [3:0]  pos;
    logic [4:0]  pos_inc;
    logic [3:0]  keypos_adv;
    logic [127:0] key_all;
    logic [7:0]  key_byte;
    logic        is_letter;
    logic [5:0]  sum;
    logic [5:0]  sum_wrap;
    logic [7:0]  enc_char;
    logic        block_full;
    logic [3:0]  fill_after;
    logic [3:0]  fill_next;
    logic [3:0]  keypos_next;
    logic [7:0]  view   [BLOCK_BYTES];
    logic [7:0]  rot    [BLOCK_BYTES];
    logic [7:0]  mixed  [BLOCK_BYTES];

    // Effective key length and current key position
    always_comb
    begin
        if (cfg.key_length == 5'd0)
        begin
            eff_len = 5'd1;
        end
        else if (cfg.key_length > 5'(KEY_MAX_LETTERS))
        begin
            eff_len = 5'(KEY_MAX_LETTERS);
        end
        else
        begin
            eff_len = cfg.key_length;
        end
        pos        = ({1'b0, keypos_reg} >= eff_len) ? 4'd0 : keypos_reg;
        pos_inc    = {1'b0, pos} + 5'd1;
        keypos_adv = (pos_inc >= eff_len) ? 4'd0 : pos_inc[3:0];
    end

    assign key_all  = {cfg.key_high, cfg.key_low};
    assign key_byte = key_all[{pos, 3'b000} +: 8];

    // Vigenere shift of the held letter
    assign is_letter = (char_reg >= LETTER_A) && (char_reg <= LETTER_Z);
    always_comb
    begin
        sum      = 6'(char_reg - LETTER_A) + {1'b0, shift_reg};
        sum_wrap = (sum >= ALPHABET) ? (sum - ALPHABET) : sum;
        enc_char = {2'b00, sum_wrap} + LETTER_A;
    end

    // Fill and key position bookkeeping for the store step
    always_comb
    begin
        block_full  = is_letter && (fill_reg == 4'(BLOCK_BYTES - 1));
        fill_after  = is_letter ? (fill_reg + 4'd1) : fill_reg;
        fill_next   = last_reg ? 4'd0 : fill_after;
        if (last_reg)
        begin
            keypos_next = 4'd0;
        end
        else if (is_letter)
        begin
            keypos_next = keypos_adv;
        end
        else
        begin
            keypos_next = keypos_reg;
        end
    end

    assign status.need_finish = block_full || (last_reg && (fill_after != 4'd0));
    assign status.emit_done   = (cnt_reg == 4'(BLOCK_BYTES - 1));

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= 4'd0;
            keypos_reg <= 4'd0;
            cnt_reg    <= 4'd0;
        end
        else
        begin
            if (cmd.store)
            begin
                fill_reg   <= fill_next;
                keypos_reg <= keypos_next;
            end
            if (cmd.finish)
            begin
                cnt_reg <= 4'd0;
            end
            else if (cmd.emit)
            begin
                cnt_reg <= cnt_reg + 4'd1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            char_reg <= in_char;
            last_reg <= in_last;
        end
        if (cmd.calc_shift)
        begin
            shift_reg <= key_shift(key_byte);
        end
        if (cmd.store)
        begin
            if (is_letter)
            begin
                store_reg[fill_reg] <= enc_char;
            end
            pad_en_reg   <= !block_full;
            pad_fill_reg <= fill_after;
            msg_end_reg  <= last_reg;
        end
        if (cmd.finish)
        begin
            for (int i = 0; i < BLOCK_BYTES; i++)
            begin
                res_reg[i] <= mixed[i];
            end
        end
    end

    // Padding, row rotation with parity, then MixColumns
    always_comb
    begin
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            view[i] = (pad_en_reg && (4'(i) >= pad_fill_reg)) ? PAD_LETTER : store_reg[i];
        end
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                rot[r*4 + c] = add_parity(view[r*4 + ((c + r) % 4)]);
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            mixed[c]      = xtime(rot[c]) ^ xtime(rot[c+4]) ^ rot[c+4]
                            ^ rot[c+8] ^ rot[c+12];
            mixed[c + 4]  = rot[c] ^ xtime(rot[c+4]) ^ xtime(rot[c+8])
                            ^ rot[c+8] ^ rot[c+12];
            mixed[c + 8]  = rot[c] ^ rot[c+4] ^ xtime(rot[c+8])
                            ^ xtime(rot[c+12]) ^ rot[c+12];
            mixed[c + 12] = xtime(rot[c]) ^ rot[c] ^ rot[c+4] ^ rot[c+8]
                            ^ xtime(rot[c+12]);
        end
    end

    // Result port
    assign out_valid   = cmd.emit;
    assign out_byte    = res_reg[cnt_reg];
    assign out_last    = cmd.emit && status.emit_done;
    assign out_msg_end = cmd.emit && status.emit_done && msg_end_reg;

endmodule
